/* sv/bfpe_pkg.sv */
// ----------------------------------------------------------------------------
// bfpe_pkg
// Shared types and constants of the Bellman-Ford path engine.
// ----------------------------------------------------------------------------
package bfpe_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int MAX_EDGES    = 4096;
  localparam int VW  = $clog2(MAX_VERTICES);   // vertex index width
  localparam int VCW = VW + 1;                 // vertex count width
  localparam int EW  = $clog2(MAX_EDGES);      // edge index width
  localparam int ECW = EW + 1;                 // edge count width
  localparam int DW  = 64;                     // distance and weight width

  typedef enum logic [1:0] {
    FN_LOAD  = 2'd0,
    FN_RUN   = 2'd1,
    FN_CLEAR = 2'd2,
    FN_QUERY = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_RANGE    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]           func;
    logic [VW-1:0]        edge_from;
    logic [VW-1:0]        edge_to;
    logic signed [DW-1:0] edge_cost;
    logic [VW-1:0]        source_vertex;
    logic [VW-1:0]        query_vertex;
  } in_t;

  typedef struct packed {
    logic [1:0]           status;
    logic                 negative_cycle;
    logic                 reached;
    logic signed [DW-1:0] distance;
    logic                 has_parent;
    logic [VW-1:0]        parent;
  } out_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;     // item taken this cycle
    logic qry_out;    // present a query result
    logic run_out;    // present a run result
    logic clr;        // clear one vertex entry
    logic src_wr;     // seed the source vertex
    logic edge_step;  // fetch next edge or close the pass
    logic vert_chk;   // edge data valid, screen it
    logic sum_calc;   // vertex data valid, form the candidate
    logic cmp;        // compare and relax
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic clr_last;
    logic run_abort;
    logic check;
    logic edge_end;
    logic stale;
    logic tail_unreached;
    logic ovf;
    logic relax;
  } sts_t;

  typedef struct packed {
    logic [VW-1:0]        tail;
    logic [VW-1:0]        head;
    logic signed [DW-1:0] weight;
  } edge_t;

  typedef struct packed {
    logic                 reach;
    logic                 pmark;
    logic [VW-1:0]        parent;
    logic signed [DW-1:0] dval;
  } vent_t;

endpackage

/* sv/bfpe_ctl.sv */
// ----------------------------------------------------------------------------
// bfpe_ctl
// Sequencer of the path engine: steps clears, passes and edge visits.
// ----------------------------------------------------------------------------
module bfpe_ctl import bfpe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] func,
  input  sts_t       sts,
  output cmd_t       cmd,
  output logic       busy
);

  typedef enum logic [9:0] {
    S_INIT = 10'b0000000001,
    S_IDLE = 10'b0000000010,
    S_QRY  = 10'b0000000100,
    S_CLR  = 10'b0000001000,
    S_SRC  = 10'b0000010000,
    S_EDGE = 10'b0000100000,
    S_VERT = 10'b0001000000,
    S_SUM  = 10'b0010000000,
    S_CMP  = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_INIT: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          if (func == FN_RUN) state_nxt = S_CLR;
          else if (func == FN_QUERY) state_nxt = S_QRY;
        end
      end
      S_QRY: begin
        cmd.qry_out = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_CLR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = sts.run_abort ? S_DONE : S_SRC;
      end
      S_SRC: begin
        cmd.src_wr = 1'b1;
        state_nxt  = S_EDGE;
      end
      S_EDGE: begin
        cmd.edge_step = 1'b1;
        if (sts.edge_end) state_nxt = sts.check ? S_DONE : S_EDGE;
        else state_nxt = S_VERT;
      end
      S_VERT: begin
        cmd.vert_chk = 1'b1;
        state_nxt    = sts.stale ? S_EDGE : S_SUM;
      end
      S_SUM: begin
        cmd.sum_calc = 1'b1;
        state_nxt    = sts.tail_unreached ? S_EDGE : S_CMP;
      end
      S_CMP: begin
        cmd.cmp = 1'b1;
        if (sts.ovf) state_nxt = S_CLR;
        else if (sts.relax && sts.check) state_nxt = S_DONE;
        else state_nxt = S_EDGE;
      end
      S_DONE: begin
        cmd.run_out = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: state_nxt = S_INIT;
    endcase
  end

endmodule

/* sv/bfpe_dp.sv */
// ----------------------------------------------------------------------------
// bfpe_dp
// Datapath: edge store, vertex store, counters, adder and result register.
// ----------------------------------------------------------------------------
module bfpe_dp import bfpe_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  in_t            in_item,
  input  cmd_t           cmd,
  input  logic           cfg_we,
  input  logic [VCW-1:0] cfg_wdata,
  output sts_t           sts,
  output logic           out_strobe,
  output out_t           out_item
);

  edge_t emem [MAX_EDGES];
  vent_t vmem [MAX_VERTICES];

  logic [VCW-1:0]       vc_r;
  logic [ECW-1:0]       loaded_r, loaded_nxt;
  logic [ECW-1:0]       e_r, e_nxt;
  logic [VW-1:0]        clr_r;
  logic [VCW-1:0]       pass_r, pass_nxt;
  logic                 changed_r, changed_nxt;
  logic                 check_r, check_nxt;
  logic                 cycle_r, cycle_nxt;
  logic [1:0]           rstat_r, rstat_nxt;
  logic [VW-1:0]        src_r, q_r;
  logic signed [DW-1:0] sum_r;
  logic                 ovf_r;
  edge_t                ed_r;
  vent_t                va_r, vb_r;
  logic                 out_strobe_r, out_strobe_nxt;
  out_t                 out_r, out_nxt;

  logic [VCW-1:0]       n;
  logic [VW-1:0]        rda_addr;
  logic signed [DW-1:0] sum;
  logic                 load_ok, load_range;
  logic                 ewe, vwe;
  logic [VW-1:0]        vw_addr;
  vent_t                vw_data;

  assign n = (vc_r > VCW'(MAX_VERTICES)) ? VCW'(MAX_VERTICES) : vc_r;

  assign load_range = ({1'b0, in_item.edge_from} >= n) || ({1'b0, in_item.edge_to} >= n);
  assign load_ok    = !load_range && (loaded_r < ECW'(MAX_EDGES));
  assign ewe        = cmd.accept && (in_item.func == FN_LOAD) && load_ok;

  assign rda_addr = cmd.accept ? in_item.query_vertex : ed_r.tail;
  assign sum      = va_r.dval + ed_r.weight;

  // Status toward the sequencer.
  assign sts.clr_last       = (clr_r == VW'(MAX_VERTICES - 1));
  assign sts.run_abort      = (rstat_r != ST_OK);
  assign sts.check          = check_r;
  assign sts.edge_end       = (e_r >= loaded_r);
  assign sts.stale          = ({1'b0, ed_r.tail} >= n) || ({1'b0, ed_r.head} >= n);
  assign sts.tail_unreached = !va_r.reach;
  assign sts.ovf            = ovf_r;
  assign sts.relax          = !vb_r.reach || (sum_r < vb_r.dval);

  // Single write port of the vertex store.
  always_comb begin
    vwe     = 1'b0;
    vw_addr = clr_r;
    vw_data = '0;
    if (cmd.clr) begin
      vwe = 1'b1;
    end else if (cmd.src_wr) begin
      vwe           = 1'b1;
      vw_addr       = src_r;
      vw_data.reach = 1'b1;
    end else if (cmd.cmp && !ovf_r && sts.relax && !check_r) begin
      vwe            = 1'b1;
      vw_addr        = ed_r.head;
      vw_data.reach  = 1'b1;
      vw_data.pmark  = 1'b1;
      vw_data.parent = ed_r.tail;
      vw_data.dval   = sum_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ewe) begin
      emem[loaded_r[EW-1:0]] <= '{tail: in_item.edge_from, head: in_item.edge_to,
                                  weight: in_item.edge_cost};
    end
    ed_r <= emem[e_r[EW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (vwe) begin
      vmem[vw_addr] <= vw_data;
    end
    va_r <= vmem[rda_addr];
    vb_r <= vmem[ed_r.head];
  end

  always_comb begin
    loaded_nxt     = loaded_r;
    e_nxt          = e_r;
    pass_nxt       = pass_r;
    changed_nxt    = changed_r;
    check_nxt      = check_r;
    cycle_nxt      = cycle_r;
    rstat_nxt      = rstat_r;
    out_strobe_nxt = 1'b0;
    out_nxt        = '0;
    out_nxt.negative_cycle = cycle_r;

    if (cmd.accept) begin
      unique case (func_t'(in_item.func))
        FN_LOAD: begin
          out_strobe_nxt = 1'b1;
          if (load_range) out_nxt.status = ST_RANGE;
          else if (!load_ok) out_nxt.status = ST_FULL;
          else loaded_nxt = loaded_r + ECW'(1);
        end
        FN_CLEAR: begin
          out_strobe_nxt = 1'b1;
          loaded_nxt     = '0;
        end
        FN_RUN: begin
          cycle_nxt = 1'b0;
          rstat_nxt = ({1'b0, in_item.source_vertex} >= n) ? ST_RANGE : ST_OK;
        end
        FN_QUERY: begin
        end
        default: begin
        end
      endcase
    end

    if (cmd.qry_out) begin
      out_strobe_nxt = 1'b1;
      if ({1'b0, q_r} >= n) begin
        out_nxt.status = ST_RANGE;
      end else begin
        out_nxt.status     = rstat_r;
        out_nxt.reached    = va_r.reach;
        out_nxt.distance   = va_r.reach ? va_r.dval : '0;
        out_nxt.has_parent = va_r.pmark;
        out_nxt.parent     = va_r.pmark ? va_r.parent : '0;
      end
    end

    if (cmd.run_out) begin
      out_strobe_nxt = 1'b1;
      out_nxt.status = rstat_r;
    end

    if (cmd.src_wr) begin
      pass_nxt    = VCW'(1);
      e_nxt       = '0;
      changed_nxt = 1'b0;
      check_nxt   = (n <= VCW'(1));
    end

    if (cmd.edge_step && sts.edge_end && !check_r) begin
      e_nxt       = '0;
      changed_nxt = 1'b0;
      if (changed_r && ({1'b0, pass_r} + (VCW + 1)'(1) < {1'b0, n})) begin
        pass_nxt = pass_r + VCW'(1);
      end else begin
        check_nxt = 1'b1;
      end
    end

    if ((cmd.vert_chk && sts.stale) || (cmd.sum_calc && !va_r.reach)) begin
      e_nxt = e_r + ECW'(1);
    end

    if (cmd.cmp) begin
      if (ovf_r) begin
        rstat_nxt = ST_OVERFLOW;
        cycle_nxt = 1'b0;
      end else if (sts.relax && check_r) begin
        cycle_nxt = 1'b1;
      end else begin
        if (sts.relax) changed_nxt = 1'b1;
        e_nxt = e_r + ECW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r         <= '0;
      loaded_r     <= '0;
      e_r          <= '0;
      clr_r        <= '0;
      pass_r       <= '0;
      changed_r    <= 1'b0;
      check_r      <= 1'b0;
      cycle_r      <= 1'b0;
      rstat_r      <= ST_OK;
      out_strobe_r <= 1'b0;
    end else begin
      if (cfg_we) vc_r <= cfg_wdata;
      if (cmd.clr) clr_r <= clr_r + VW'(1);
      loaded_r     <= loaded_nxt;
      e_r          <= e_nxt;
      pass_r       <= pass_nxt;
      changed_r    <= changed_nxt;
      check_r      <= check_nxt;
      cycle_r      <= cycle_nxt;
      rstat_r      <= rstat_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (cmd.accept) begin
      src_r <= in_item.source_vertex;
      q_r   <= in_item.query_vertex;
    end
    if (cmd.sum_calc) begin
      sum_r <= sum;
      ovf_r <= (va_r.dval[DW-1] == ed_r.weight[DW-1]) && (sum[DW-1] != va_r.dval[DW-1]);
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_r;

endmodule

/* sv/bellman_ford_path_engine_core.sv */
// ----------------------------------------------------------------------------
// bellman_ford_path_engine_core
// Single-source shortest paths over a loaded edge list, Bellman-Ford style.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; every item yields
// exactly one result, shown for one cycle with out_strobe high, and the
// receiver cannot stall it, so it must capture the result in that cycle.
// Load and clear items leave busy low and their result appears on the
// next cycle, so a new item may follow at once. A query item reads the
// vertex store and holds busy high while its result is formed. A run item
// holds busy high for the whole run: a clearing sweep over the vertex
// store, a step to seed the source, then relaxation passes in which each
// stored edge goes through edge fetch, vertex fetch, add, and compare and
// write back, leaving early when screened out, for at most the vertex
// count less one passes and one check pass, and a last step to report.
// An overflowing run sweeps the vertex store again before it reports.
// After reset the block also sweeps the vertex store with busy high;
// writes of the vertex count are taken at any time but belong in idle periods.
// ----------------------------------------------------------------------------
module bellman_ford_path_engine_core import bfpe_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  in_t            in_item,
  output logic           out_strobe,
  output out_t           out_item,
  input  logic           cfg_we,
  input  logic [VCW-1:0] cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  // The sequencer walks the run; of the item it sees only the function code.
  bfpe_ctl u_ctl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .func  (in_item.func),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // The datapath holds both stores, the adder and the result register.
  bfpe_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cmd        (cmd),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .sts        (sts),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule
